FILE: hw/rtl/brq_pkg.sv
// Shared types and codes for the bitmap priority ready queue.
// No dependencies; imported by every module of the block.
`default_nettype none
package brq_pkg;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_NOTQ  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] task_id;
    logic [4:0] task_prio;
    logic       cur_valid;
    logic [5:0] cur_task;
    logic [4:0] cur_prio;
  } in_t;

  typedef struct packed {
    logic [5:0] picked_task;
    logic       picked_valid;
    logic       preempt;
    logic [1:0] status;
    logic [6:0] running_count;
  } out_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [5:0] tid;
    logic       tid_ok;
    logic [4:0] prio;
    logic       resched;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/brq_front.sv
// Front end: accepts input beats, classifies them, holds them in a two-entry queue.
// Depends on brq_pkg.
`default_nettype none
module brq_front #(
  parameter int NUM_TASKS = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  brq_pkg::in_t     in_data_i,
  output logic             cmd_valid_o,
  input  wire              cmd_pop_i,
  output brq_pkg::cmd_t    cmd_o
);
  import brq_pkg::*;

  cmd_t       fifo_q [2];
  cmd_t       cls;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_comb begin
    cls.op      = in_data_i.operation;
    cls.tid     = in_data_i.task_id;
    cls.tid_ok  = (32'(in_data_i.task_id) < NUM_TASKS);
    cls.prio    = in_data_i.task_prio;
    cls.resched = in_data_i.cur_valid && (in_data_i.cur_task != in_data_i.task_id) &&
                  (in_data_i.task_prio < in_data_i.cur_prio);
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/brq_back.sv
// Back end: sequencer over the level and link tables, bitmap, flags and count.
// Depends on brq_pkg; fed by brq_front.
`default_nettype none
module brq_back #(
  parameter int NUM_LEVELS = 32,
  parameter int NUM_TASKS  = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cmd_valid_i,
  output logic             cmd_pop_o,
  input  brq_pkg::cmd_t    cmd_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output brq_pkg::out_t    out_data_o
);
  import brq_pkg::*;

  localparam int TW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LW  = $clog2(NUM_TASKS + 1);
  localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW  = $clog2(NUM_TASKS + 1);
  localparam logic [LW-1:0] NONE = LW'(NUM_TASKS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAIL = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            st_q, st_d;
  logic [NUM_LEVELS-1:0] bm_q, bm_d;
  logic [NUM_TASKS-1:0]  flag_q, flag_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [TW-1:0]         tid_q, tid_d;
  logic [LVW-1:0]        lv_q, lv_d;
  logic                  rsch_q, rsch_d, pick_q, pick_d;
  out_t                  res_q, res_d;

  logic [TW-1:0]  head_mem [NUM_LEVELS];
  logic [TW-1:0]  tail_mem [NUM_LEVELS];
  logic [LW-1:0]  next_mem [NUM_TASKS];
  logic [LW-1:0]  prev_mem [NUM_TASKS];
  logic [LVW-1:0] lvl_mem  [NUM_TASKS];

  logic           head_we, head_re, tail_we, tail_re;
  logic [LVW-1:0] head_wa, head_ra, tail_wa, tail_ra;
  logic [TW-1:0]  head_wd, tail_wd, head_rd, tail_rd;
  logic           next_we, prev_we, lvl_we, link_re;
  logic [TW-1:0]  next_wa, prev_wa, lvl_wa, link_ra;
  logic [LW-1:0]  next_wd, prev_wd, next_rd, prev_rd;
  logic [LVW-1:0] lvl_wd, lvl_rd;

  logic [TW-1:0]  cidx;
  logic [LVW-1:0] csat, ffs;

  assign cidx = TW'(cmd_i.tid);
  assign csat = (32'(cmd_i.prio) < NUM_LEVELS) ? LVW'(cmd_i.prio) : LVW'(NUM_LEVELS - 1);

  always_comb begin
    ffs = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (bm_q[i]) ffs = LVW'(i);
    end
  end

  always_comb begin
    st_d = st_q; bm_d = bm_q; flag_d = flag_q; cnt_d = cnt_q;
    tid_d = tid_q; lv_d = lv_q; rsch_d = rsch_q; pick_d = pick_q; res_d = res_q;
    cmd_pop_o = 1'b0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_re = 1'b0; head_ra = '0;
    tail_we = 1'b0; tail_wa = '0; tail_wd = '0; tail_re = 1'b0; tail_ra = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0;
    link_re = 1'b0; link_ra = '0;
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          res_d     = '0;
          tid_d     = cidx;
          lv_d      = csat;
          rsch_d    = cmd_i.resched;
          pick_d    = 1'b0;
          st_d      = S_OUT;
          case (cmd_i.op)
            OP_ENQ: begin
              if (!cmd_i.tid_ok) begin
                res_d.status = ST_NOTQ;
              end else if (flag_q[cidx]) begin
                res_d.status = ST_DUP;
              end else begin
                next_we = 1'b1; next_wa = cidx; next_wd = NONE;
                lvl_we  = 1'b1; lvl_wa  = cidx; lvl_wd  = csat;
                flag_d[cidx] = 1'b1;
                cnt_d = cnt_q + CW'(1);
                if (bm_q[csat]) begin
                  tail_re = 1'b1; tail_ra = csat;
                  st_d = S_TAIL;
                end else begin
                  head_we = 1'b1; head_wa = csat; head_wd = cidx;
                  tail_we = 1'b1; tail_wa = csat; tail_wd = cidx;
                  prev_we = 1'b1; prev_wa = cidx; prev_wd = NONE;
                  bm_d[csat] = 1'b1;
                  res_d.preempt = cmd_i.resched;
                end
              end
            end
            OP_DEQ: begin
              if (!cmd_i.tid_ok || !flag_q[cidx]) begin
                res_d.status = ST_NOTQ;
              end else begin
                link_re = 1'b1; link_ra = cidx;
                st_d = S_LINK;
              end
            end
            OP_PICK: begin
              if (cnt_q == '0 || bm_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                head_re = 1'b1; head_ra = ffs;
                st_d = S_HEAD;
              end
            end
            default: res_d.status = ST_OK;
          endcase
        end
      end
      S_TAIL: begin
        next_we = 1'b1; next_wa = tail_rd; next_wd = LW'(tid_q);
        prev_we = 1'b1; prev_wa = tid_q;   prev_wd = LW'(tail_rd);
        tail_we = 1'b1; tail_wa = lv_q;    tail_wd = tid_q;
        res_d.preempt = rsch_q;
        st_d = S_OUT;
      end
      S_HEAD: begin
        tid_d   = head_rd;
        pick_d  = 1'b1;
        link_re = 1'b1; link_ra = head_rd;
        st_d    = S_LINK;
      end
      S_LINK: begin
        // splice neighbours; a missing side updates head or tail instead
        if (prev_rd != NONE) begin
          next_we = 1'b1; next_wa = TW'(prev_rd); next_wd = next_rd;
        end else begin
          head_we = 1'b1; head_wa = lvl_rd; head_wd = TW'(next_rd);
        end
        if (next_rd != NONE) begin
          prev_we = 1'b1; prev_wa = TW'(next_rd); prev_wd = prev_rd;
        end else begin
          tail_we = 1'b1; tail_wa = lvl_rd; tail_wd = TW'(prev_rd);
        end
        if (prev_rd == NONE && next_rd == NONE) bm_d[lvl_rd] = 1'b0;
        flag_d[tid_q] = 1'b0;
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
        res_d.picked_valid = pick_q;
        res_d.picked_task  = pick_q ? 6'(tid_q) : 6'd0;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_data_o = res_q;
    out_data_o.running_count = 7'(cnt_q);
  end
  assign out_valid_o = (st_q == S_OUT);

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_rd <= tail_mem[tail_ra];
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (lvl_we)  lvl_mem[lvl_wa]   <= lvl_wd;
    if (link_re) begin
      next_rd <= next_mem[link_ra];
      prev_rd <= prev_mem[link_ra];
      lvl_rd  <= lvl_mem[link_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q  <= tid_d;
    lv_q   <= lv_d;
    rsch_q <= rsch_d;
    pick_q <= pick_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      bm_q   <= '0;
      flag_q <= '0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      bm_q   <= bm_d;
      flag_q <= flag_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bitmap_priority_ready_queue.sv
// Top level of the bitmap priority ready queue: front queue plus table sequencer.
// Depends on brq_pkg, brq_front and brq_back.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+------------------------
//   input   | in_valid_i | in_stall_o  | in_data_i  (in_t)
//   output  | out_valid_o| out_stall_i | out_data_o (out_t)
//
// Each beat runs from idle to the result state: a rejected command, a no-op or an
// enqueue to an empty level goes directly, an enqueue to a busy level via the tail
// state, a dequeue via the link state, a pick via the head and link states, each
// state set by a registered table read; the result holds while out_stall_i is high.
// Reset clears bitmap, queued flags and count; the tables need no clearing.
// The two-entry front queue keeps taking beats while a result stalls, until full.
`default_nettype none
module bitmap_priority_ready_queue #(
  parameter int NUM_LEVELS = 32,
  parameter int NUM_TASKS  = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  brq_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output brq_pkg::out_t    out_data_o
);
  import brq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  // front: classify and buffer
  brq_front #(.NUM_TASKS(NUM_TASKS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  // back: run each command against the tables
  brq_back #(.NUM_LEVELS(NUM_LEVELS), .NUM_TASKS(NUM_TASKS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
`default_nettype wire
